// ----- sv/pmp_pkg.sv -----
// Shared types and constants for the PMP region permission checker.
// Used by pmp_cell, pmp_region_permission_check and pmp_checker; no dependencies.
`timescale 1ns / 1ps

package pmp_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ENTRIES_DEF = 16;
  localparam int IDX_W       = 4;
  localparam int WORD_W      = 54;
  localparam int ADDR_W      = 64;
  localparam int CFG_W       = 64;
  localparam int PADDR_W     = 4;
  localparam int RANGE_W     = WORD_W + 4;
  localparam int LOCK_BIT    = 7;

  // Low config register value that, with entry 0 all ones, opens the whole space.
  localparam logic [CFG_W-1:0] FULL_RANGE_CFG = 64'h0f;

  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  localparam logic [2:0] NEED_R = 3'b001;
  localparam logic [2:0] NEED_W = 3'b010;
  localparam logic [2:0] NEED_X = 3'b100;

  typedef enum logic {
    OP_CHECK,
    OP_WRITE
  } pmp_op_t;

  typedef enum logic [1:0] {
    KIND_FETCH,
    KIND_LOAD,
    KIND_STORE
  } pmp_kind_t;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_TOR,
    MODE_NA4,
    MODE_NAPOT
  } pmp_mode_t;

  typedef enum logic {
    REG_CFG_LOW,
    REG_CFG_HIGH
  } pmp_reg_t;

  // One item as it travels down the chain of cells.
  typedef struct packed {
    logic              vld;
    logic              is_wr;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] wword;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W:0]   last;   // top bit set when the access runs past the address space
    logic [2:0]        need;
    logic              mach;
    logic              done;
    logic              perm;
    logic              any;
  } pmp_item_t;

endpackage

// ----- sv/pmp_cell.sv -----
// One PMP entry: holds the entry's address word and checks passing items against it.
// Depends on pmp_pkg.
`timescale 1ns / 1ps

module pmp_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [7:0]                  cfg_byte,
  input  logic [pmp_pkg::WORD_W-1:0]  prev_word,
  input  pmp_pkg::pmp_item_t          item_i,
  output pmp_pkg::pmp_item_t          item_o,
  output logic [pmp_pkg::WORD_W-1:0]  word_o
);
  import pmp_pkg::*;

  logic [WORD_W-1:0]  word_r;
  logic [WORD_W-1:0]  word_nxt;
  pmp_item_t          item_r;
  pmp_item_t          item_nxt;
  pmp_mode_t          mode;
  logic [WORD_W:0]    inc;
  logic [WORD_W:0]    pow;
  logic [WORD_W-1:0]  tmask;
  logic [RANGE_W-1:0] lo;
  logic [RANGE_W-1:0] hi;
  logic               hit;
  logic               allow;

  assign mode = pmp_mode_t'(cfg_byte[4:3]);

  // Adding one to the word clears its trailing ones and sets the next bit,
  // which gives both the NAPOT size and the mask of the trailing ones.
  assign inc   = {1'b0, word_r} + (WORD_W+1)'(1);
  assign pow   = inc & ~{1'b0, word_r};
  assign tmask = WORD_W'((inc ^ {1'b0, word_r}) >> 1);

  always_comb begin
    unique case (mode)
      MODE_OFF: begin
        lo = '0;
        hi = '0;
      end
      MODE_TOR: begin
        lo = RANGE_W'({prev_word, 2'b00});
        hi = RANGE_W'({word_r, 2'b00});
      end
      MODE_NA4: begin
        lo = RANGE_W'({word_r, 2'b00});
        hi = RANGE_W'({word_r, 2'b00}) + RANGE_W'(4);
      end
      MODE_NAPOT: begin
        lo = RANGE_W'({word_r & ~tmask, 2'b00});
        hi = RANGE_W'({word_r & ~tmask, 2'b00}) + {pow, 3'b000};
      end
    endcase
  end

  assign hit = (mode != MODE_OFF) && !item_i.last[ADDR_W]
            && (item_i.addr >= ADDR_W'(lo))
            && (item_i.last[ADDR_W-1:0] < ADDR_W'(hi));

  assign allow = (item_i.mach && !cfg_byte[LOCK_BIT]) || (|(cfg_byte[2:0] & item_i.need));

  always_comb begin
    item_nxt = item_i;
    if (item_i.vld && !item_i.is_wr && !item_i.done) begin
      if (mode != MODE_OFF) begin
        item_nxt.any = 1'b1;
      end
      if (hit) begin
        item_nxt.done = 1'b1;
        item_nxt.perm = allow;
      end
    end
  end

  always_comb begin
    word_nxt = word_r;
    if (adv && item_i.vld && item_i.is_wr && (item_i.idx == IDX_W'(IDX))) begin
      word_nxt = item_i.wword;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r     <= '0;
      item_r.vld <= 1'b0;
    end else begin
      word_r <= word_nxt;
      if (adv) begin
        item_r <= item_nxt;
      end
    end
  end

  assign item_o = item_r;
  assign word_o = word_r;

endmodule

// ----- sv/pmp_region_permission_check.sv -----
// Top level of the PMP region permission checker: entry stage, chain of entry cells,
// result register and the configuration registers. Depends on pmp_pkg and pmp_cell.
//
// Usage: an item on the in_ channel either writes a region address word into one
// entry (operation 1, no result) or checks one access (operation 0, one result on
// the out_ channel carrying permitted). Both channels use valid/ready. The two
// 64-bit config registers sit on the cfg_ APB-style port at byte addresses 0 and 8.
// The user must write them only while the block is idle; the block does not enforce
// it. pready is always high. Each item passes an entry register and then one cell
// per entry, and a check result is captured in the output register after the last
// cell. Items follow each other down the chain; one item is taken per cycle unless
// the chain halts, and writes reach their cell in order with the checks.
// Reset clears the config registers, every entry word and all valid flags.
// While a result waits in the output register and out_ready is low, the chain
// halts only when the item at its end is also a check; otherwise it moves on.
`timescale 1ns / 1ps

module pmp_region_permission_check #(
  parameter int ENTRIES = pmp_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [pmp_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [pmp_pkg::WORD_W-1:0]   in_address_word,
  input  logic [pmp_pkg::ADDR_W-1:0]   in_check_address,
  input  logic [3:0]                   in_access_size,
  input  logic [1:0]                   in_access_kind,
  input  logic [1:0]                   in_privilege,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_permitted,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pmp_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [pmp_pkg::CFG_W-1:0]    cfg_pwdata,
  output logic [pmp_pkg::CFG_W-1:0]    cfg_prdata,
  output logic                         cfg_pready
);
  import pmp_pkg::*;

  logic [CFG_W-1:0]  cfg_low_r;
  logic [CFG_W-1:0]  cfg_low_nxt;
  logic [CFG_W-1:0]  cfg_high_r;
  logic [CFG_W-1:0]  cfg_high_nxt;
  logic              cfg_wr;
  pmp_reg_t          cfg_sel;

  pmp_item_t         in_item;
  pmp_item_t         entry_r;
  pmp_item_t         entry_nxt;
  pmp_item_t         head;
  pmp_item_t         tail;
  pmp_item_t         chain [0:ENTRIES];
  logic [WORD_W-1:0] words [0:ENTRIES-1];
  logic [3:0]        size_m1;

  logic              adv;
  logic              tail_check;
  logic              verdict;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_perm_r;
  logic              out_perm_nxt;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = pmp_reg_t'(cfg_paddr[3]);

  always_comb begin
    cfg_low_nxt  = cfg_low_r;
    cfg_high_nxt = cfg_high_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        REG_CFG_LOW:  cfg_low_nxt  = cfg_pwdata;
        REG_CFG_HIGH: cfg_high_nxt = cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_CFG_LOW:  cfg_prdata = cfg_low_r;
      REG_CFG_HIGH: cfg_prdata = cfg_high_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_low_r  <= '0;
      cfg_high_r <= '0;
    end else begin
      cfg_low_r  <= cfg_low_nxt;
      cfg_high_r <= cfg_high_nxt;
    end
  end

  // Entry stage: work out the last byte and the permission bit the access needs.
  assign size_m1 = (in_access_size == 4'd0) ? 4'd0 : 4'(in_access_size - 4'd1);

  always_comb begin
    in_item       = '0;
    in_item.vld   = 1'b1;
    in_item.is_wr = (in_operation == OP_WRITE);
    in_item.idx   = in_entry_index;
    in_item.wword = in_address_word;
    in_item.addr  = in_check_address;
    in_item.last  = {1'b0, in_check_address} + (ADDR_W+1)'(size_m1);
    in_item.mach  = (in_privilege == PRIV_MACHINE);
    unique case (in_access_kind)
      KIND_FETCH: in_item.need = NEED_X;
      KIND_LOAD:  in_item.need = NEED_R;
      default:    in_item.need = NEED_W;
    endcase
  end

  always_comb begin
    entry_nxt     = in_item;
    entry_nxt.vld = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.vld <= 1'b0;
    end else if (adv) begin
      entry_r <= entry_nxt;
    end
  end

  // The full-range shortcut settles a check before it enters the first cell.
  always_comb begin
    head = entry_r;
    if (entry_r.vld && !entry_r.is_wr && (cfg_low_r == FULL_RANGE_CFG) && (&words[0])) begin
      head.done = 1'b1;
      head.perm = 1'b1;
    end
  end

  assign chain[0] = head;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [7:0]        cbyte;
    logic [WORD_W-1:0] prev;

    if (i < 8) begin : g_low
      assign cbyte = cfg_low_r[8*i +: 8];
    end else begin : g_high
      assign cbyte = cfg_high_r[8*(i-8) +: 8];
    end

    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = words[i-1];
    end

    pmp_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cfg_byte (cbyte),
      .prev_word(prev),
      .item_i   (chain[i]),
      .item_o   (chain[i+1]),
      .word_o   (words[i])
    );
  end

  // Result register.
  assign tail       = chain[ENTRIES];
  assign tail_check = tail.vld && !tail.is_wr;
  assign adv        = !out_valid_r || out_ready || !tail_check;
  assign in_ready   = adv;
  assign verdict    = tail.done ? tail.perm : (!tail.any || tail.mach);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_perm_nxt  = out_perm_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && tail_check) begin
      out_valid_nxt = 1'b1;
      out_perm_nxt  = verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_perm_r  <= out_perm_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_permitted = out_perm_r;

endmodule

// ----- sv/pmp_checker.sv -----
// Port-level checks for the PMP region permission checker, bound to the top level.
// Depends on pmp_pkg and pmp_region_permission_check.
`timescale 1ns / 1ps

module pmp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_permitted,
  input logic                         cfg_psel,
  input logic                         cfg_penable,
  input logic                         cfg_pwrite,
  input logic [pmp_pkg::PADDR_W-1:0]  cfg_paddr,
  input logic [pmp_pkg::CFG_W-1:0]    cfg_pwdata,
  input logic [pmp_pkg::CFG_W-1:0]    cfg_prdata
);
  import pmp_pkg::*;

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> out_valid && $stable(out_permitted))
    else $error("result changed or vanished while stalled");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // With the result register empty the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // A register reads back what was just written to it.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_psel && cfg_penable && cfg_pwrite
    |=> (cfg_paddr[3] != $past(cfg_paddr[3])) || (cfg_prdata == $past(cfg_pwdata)))
    else $error("config register read-back mismatch");

endmodule

bind pmp_region_permission_check pmp_checker u_pmp_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking testbench for pmp_region_permission_check: directed table, then random phases.
// Depends on pmp_pkg and the RTL; expected results come from the table or an in-file predictor.
`timescale 1ns / 1ps

module testbench;
  import pmp_pkg::*;

  localparam int LATENCY = ENTRIES_DEF + 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 80;
  localparam int HOLD_CYCLES = 80;

  localparam logic [1:0] PRIV_USER = 2'd0;
  localparam logic [1:0] PRIV_SUPER = 2'd1;
  localparam logic [1:0] PRIV_RESERVED = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic NO_CFG = 1'b0;
  localparam logic NEW_CFG = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam logic TYPED = 1'b1;

  typedef struct packed {
    pmp_op_t           op;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic [ADDR_W-1:0] addr;
    logic [3:0]        size;
    logic [1:0]        kind;
    logic [1:0]        priv;
  } access_item_t;

  typedef struct packed {
    logic         new_cfg;
    logic [63:0]  cfg_lo;
    logic [63:0]  cfg_hi;
    access_item_t item;
    logic         typed;
    logic         want;
  } plan_row_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_operation = 1'b0;
  logic [IDX_W-1:0]    in_entry_index = '0;
  logic [WORD_W-1:0]   in_address_word = '0;
  logic [ADDR_W-1:0]   in_check_address = '0;
  logic [3:0]          in_access_size = '0;
  logic [1:0]          in_access_kind = '0;
  logic [1:0]          in_privilege = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_permitted;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_W-1:0]    cfg_pwdata = '0;
  logic [CFG_W-1:0]    cfg_prdata;
  logic                cfg_pready;

  // Shadow copy of the block's state, updated as items are accepted and registers written.
  logic [CFG_W-1:0]  cfg_low_shadow = '0;
  logic [CFG_W-1:0]  cfg_high_shadow = '0;
  logic [WORD_W-1:0] region_words [MAX_ENTRIES];
  logic              pending_permits [$];
  plan_row_t         plan [$];

  int   fail_count = 0;
  int   cycle_count = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   holds_asked = 0;
  int   holds_done = 0;
  int   hold_left = 0;
  logic want_perm;

  pmp_region_permission_check i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_entry_index   (in_entry_index),
    .in_address_word  (in_address_word),
    .in_check_address (in_check_address),
    .in_access_size   (in_access_size),
    .in_access_kind   (in_access_kind),
    .in_privilege     (in_privilege),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_permitted    (out_permitted),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Handshakes are sampled at the falling edge, when every signal has settled.
  always @(negedge clk) begin
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_permits.size() == 0) begin
        $display("%0t: result with nothing expected, actual permitted=%0b", $time, out_permitted);
        fail_count++;
      end else begin
        want_perm = pending_permits.pop_front();
        if (out_permitted !== want_perm) begin
          $display("%0t: permitted mismatch, expected %0b, actual %0b",
                   $time, want_perm, out_permitted);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [7:0] entry_cfg(int i);
    logic [CFG_W-1:0] r;
    r = (i < 8) ? cfg_low_shadow : cfg_high_shadow;
    return r[(i % 8) * 8 +: 8];
  endfunction

  // Byte range [lo, hi) covered by entry i under its present mode.
  function automatic void region_of(input int i, output logic [65:0] lo, output logic [65:0] hi);
    logic [7:0]        ent;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] keep;
    int                n;
    ent = entry_cfg(i);
    w = region_words[i];
    n = 0;
    case (pmp_mode_t'(ent[4:3]))
      MODE_TOR: begin
        lo = (i == 0) ? 66'd0 : 66'({region_words[(i + MAX_ENTRIES - 1) % MAX_ENTRIES], 2'b00});
        hi = 66'({w, 2'b00});
      end
      MODE_NAPOT: begin
        while (n < WORD_W && w[n]) n++;
        keep = ~((54'd1 << n) - 54'd1);
        lo = 66'({w & keep, 2'b00});
        hi = lo + (66'd8 << n);
      end
      default: begin
        lo = 66'({w, 2'b00});
        hi = lo + 66'd4;
      end
    endcase
  endfunction

  function automatic logic permitted_for(access_item_t a);
    logic [64:0] last;
    logic [65:0] lo;
    logic [65:0] hi;
    logic [7:0]  ent;
    logic [2:0]  need;
    logic        active_seen;
    if (cfg_low_shadow == FULL_RANGE_CFG && region_words[0] == '1) return 1'b1;
    need = (a.kind == KIND_FETCH) ? NEED_X : (a.kind == KIND_LOAD) ? NEED_R : NEED_W;
    last = {1'b0, a.addr} + ((a.size == 4'd0) ? 65'd0 : 65'(a.size) - 65'd1);
    active_seen = 1'b0;
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      ent = entry_cfg(i);
      if (pmp_mode_t'(ent[4:3]) == MODE_OFF) continue;
      active_seen = 1'b1;
      region_of(i, lo, hi);
      // Only an entry that holds every byte of the access decides.
      if (!last[64] && {2'b00, a.addr} >= lo && {1'b0, last} < hi) begin
        if (a.priv == PRIV_MACHINE && !ent[LOCK_BIT]) return 1'b1;
        return (ent[2:0] & need) != 3'b000;
      end
    end
    if (!active_seen) return 1'b1;
    return a.priv == PRIV_MACHINE;
  endfunction

  function automatic access_item_t check_of(logic [63:0] a, logic [3:0] s, logic [1:0] k,
                                            logic [1:0] p);
    access_item_t it;
    it = '0;
    it.op = OP_CHECK;
    it.addr = a;
    it.size = s;
    it.kind = k;
    it.priv = p;
    return it;
  endfunction

  function automatic access_item_t write_of(logic [3:0] i, logic [WORD_W-1:0] w);
    access_item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.idx = i;
    it.word = w;
    return it;
  endfunction

  // Checks mostly land on the edges of a present region, so that partial overlaps are common.
  function automatic access_item_t random_access();
    logic [65:0]       lo;
    logic [65:0]       hi;
    logic [WORD_W-1:0] w;
    logic [63:0]       a;
    int                n;
    int                pick;
    int                sz;
    if ($urandom_range(0, 3) == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        w = 54'($urandom_range(0, 'h3ff));
      end else if (pick < 7) begin
        n = $urandom_range(0, 10);
        w = (54'($urandom_range(0, 'h3f)) << (n + 1)) | ((54'd1 << n) - 54'd1);
      end else if (pick == 7) begin
        w = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end else begin
        w = 54'({$urandom, $urandom});
      end
      return write_of(4'($urandom_range(0, 15)), w);
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      region_of($urandom_range(0, 15), lo, hi);
      a = ((pick < 3) ? lo[63:0] : hi[63:0] - 64'd8) + 64'($urandom_range(0, 15)) - 64'd4;
    end else if (pick < 8) begin
      a = 64'($urandom_range(0, 'h1fff));
    end else if (pick == 8) begin
      a = '1 - 64'($urandom_range(0, 15));
    end else begin
      a = {$urandom, $urandom};
    end
    sz = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    return check_of(a, 4'(sz), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endfunction

  task automatic offer(input access_item_t a, input logic typed, input logic want);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= a.op;
    in_entry_index <= a.idx;
    in_address_word <= a.word;
    in_check_address <= a.addr;
    in_access_size <= a.size;
    in_access_kind <= a.kind;
    in_privilege <= a.priv;
    @(negedge clk);
    while (in_ready !== 1'b1) @(negedge clk);
    // The item is taken at the coming rising edge.
    if (a.op == OP_WRITE) region_words[a.idx] = a.word;
    else pending_permits.push_back(typed ? want : permitted_for(a));
    @(posedge clk);
  endtask

  // Waits for every expected result, then for writes still travelling down the chain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_permits.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input pmp_reg_t r, input logic [CFG_W-1:0] v);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {r, 3'b000};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (cfg_pready !== 1'b1) @(negedge clk);
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (r == REG_CFG_LOW) cfg_low_shadow = v;
    else cfg_high_shadow = v;
    @(posedge clk);
  endtask

  task automatic build_plan();
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of(64'h0, 4'd0, KIND_LOAD, PRIV_USER),
                     TYPED, 1'b1});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of('1, 4'd15, KIND_RESERVED, PRIV_RESERVED),
                     TYPED, 1'b1});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, write_of(4'd0, '1), PREDICTED, 1'b0});
    // Full-range shortcut: entry 0 all ones with the low register exactly 0x0f.
    plan.push_back('{NEW_CFG, FULL_RANGE_CFG, 64'h0, check_of('1, 4'd8, KIND_STORE, PRIV_USER),
                     TYPED, 1'b1});
    plan.push_back('{NEW_CFG, 64'h0e, 64'h0, check_of(64'h0, 4'd1, KIND_LOAD, PRIV_USER),
                     TYPED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of(64'h100, 4'd0, KIND_STORE, PRIV_SUPER),
                     TYPED, 1'b1});
    plan.push_back('{NO_CFG, 64'h0, 64'h0,
                     check_of(64'h8000_0000_0000_0000, 4'd4, KIND_LOAD, PRIV_USER), TYPED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0,
                     check_of(64'h8000_0000_0000_0000, 4'd4, KIND_LOAD, PRIV_MACHINE),
                     TYPED, 1'b1});
    // An access running past the top of the address space matches nothing.
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of('1, 4'd2, KIND_FETCH, PRIV_MACHINE),
                     TYPED, 1'b1});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, write_of(4'd1, 54'h100), PREDICTED, 1'b0});
    plan.push_back('{NEW_CFG, 64'h9100, 64'h0, check_of(64'h400, 4'd4, KIND_LOAD, PRIV_MACHINE),
                     TYPED, 1'b1});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of(64'h400, 4'd4, KIND_STORE, PRIV_MACHINE),
                     TYPED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of(64'h402, 4'd4, KIND_LOAD, PRIV_MACHINE),
                     TYPED, 1'b1});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of(64'h402, 4'd4, KIND_LOAD, PRIV_USER),
                     TYPED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, write_of(4'd2, 54'h3), PREDICTED, 1'b0});
    plan.push_back('{NEW_CFG, 64'h0b1c_9100, 64'h0,
                     check_of(64'h1f, 4'd1, KIND_FETCH, PRIV_USER), PREDICTED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of(64'h1c, 4'd8, KIND_FETCH, PRIV_USER),
                     PREDICTED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, write_of(4'd3, 54'h100), PREDICTED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of(64'h10, 4'd9, KIND_LOAD, PRIV_SUPER),
                     PREDICTED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of(64'h20, 4'd0, KIND_LOAD, PRIV_USER),
                     PREDICTED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, write_of(4'd15, '1), PREDICTED, 1'b0});
    plan.push_back('{NEW_CFG, 64'h0b1c_9100, 64'h1800_0000_0000_0000,
                     check_of(64'h01ff_ffff_ffff_fff8, 4'd8, KIND_RESERVED, PRIV_RESERVED),
                     PREDICTED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0,
                     check_of(64'h0200_0000_0000_0000, 4'd1, KIND_STORE, PRIV_USER),
                     PREDICTED, 1'b0});
    plan.push_back('{NO_CFG, 64'h0, 64'h0, check_of(64'h3fc, 4'd4, KIND_FETCH, PRIV_MACHINE),
                     PREDICTED, 1'b0});
  endtask

  initial begin
    logic [CFG_W-1:0] lo_val;
    logic [CFG_W-1:0] hi_val;
    foreach (region_words[i]) region_words[i] = '0;
    build_plan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].new_cfg) begin
        settle();
        write_reg(REG_CFG_LOW, plan[r].cfg_lo);
        write_reg(REG_CFG_HIGH, plan[r].cfg_hi);
      end
      offer(plan[r].item, plan[r].typed, plan[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      lo_val = {$urandom, $urandom};
      hi_val = {$urandom, $urandom};
      case (ph)
        0: begin
          lo_val = '0;
          hi_val = '0;
        end
        3: begin
          lo_val = '1;
          hi_val = '1;
        end
        5: hi_val = '0;
        default: ;
      endcase
      write_reg(REG_CFG_LOW, lo_val);
      write_reg(REG_CFG_HIGH, hi_val);
      case (ph % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 45;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 45;
        end
        default: begin
          gap_pct = 36;
          stall_pct = 36;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // A long hold-off on the result side lets the chain fill and stall the input.
        if (ph == 2 && k == 8) holds_asked++;
        if (ph == 1 && k == PHASE_ITEMS / 2) settle();
        offer(random_access(), PREDICTED, 1'b0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
